@@ design/dtl_pkg.sv @@
`default_nettype none

package dtl_pkg;

   localparam int MAX_SYMBOL_DEFAULT = 64;
   localparam logic [6:0] MAX_LENGTH_RESET = 7'd64;
   localparam logic [30:0] MAG_MAX = 31'h7FFF_FFFF;
   localparam logic [31:0] DIV10_RECIP = 32'hCCCC_CCCD;
   localparam int DIV10_SHIFT = 35;
   localparam logic [6:0] SCALE_MAX = 7'h7F;
   localparam logic [6:0] SCALE_DIV_LIMIT = 7'd10;

   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_POINT = 8'h2E;
   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_DIGIT_LO = 8'd48;
   localparam logic [7:0] CHAR_DIGIT_HI = 8'd57;
   localparam logic [7:0] CHAR_ALPHA_LO = 8'd65;
   localparam logic [7:0] CHAR_ALPHA_HI = 8'd122;

   typedef enum logic [1:0] {
      CMD_BEGIN   = 2'd0,
      CMD_PRESENT = 2'd1,
      CMD_READ    = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DIV,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic capture;
      logic execute;
      logic div_step;
      logic emit;
   } ctl_cmd_type;

   typedef struct packed {
      logic div_done;
      logic slot_free;
   } dp_status_type;

   function automatic logic is_digit(input logic [7:0] b);
      return (b >= CHAR_DIGIT_LO) && (b <= CHAR_DIGIT_HI);
   endfunction

   function automatic logic is_accepted(input logic [7:0] b);
      return (b == CHAR_MINUS) || (b == CHAR_POINT) || (b == CHAR_COMMA) || is_digit(b)
         || ((b >= CHAR_ALPHA_LO) && (b <= CHAR_ALPHA_HI));
   endfunction

endpackage

`default_nettype wire

@@ design/dtl_ifs.sv @@
`default_nettype none

interface dtl_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] command;
   logic [7:0] character;
   logic [5:0] read_index;

   modport source (output valid, command, character, read_index, input ready);
   modport sink (input valid, command, character, read_index, output ready);
endinterface

interface dtl_rsp_if;
   logic               valid;
   logic               ready;
   logic               complete;
   logic [7:0]         last_char;
   logic [6:0]         token_length;
   logic [30:0]        magnitude;
   logic               is_negative;
   logic [6:0]         scale;
   logic signed [31:0] int_value;
   logic [7:0]         read_char;

   modport source (output valid, complete, last_char, token_length, magnitude, is_negative,
                   scale, int_value, read_char, input ready);
   modport sink (input valid, complete, last_char, token_length, magnitude, is_negative,
                 scale, int_value, read_char, output ready);
endinterface

`default_nettype wire

@@ design/dtl_ctrl.sv @@
`default_nettype none

module dtl_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   input  wire dtl_pkg::dp_status_type status,
   output logic                        req_ready,
   output dtl_pkg::ctl_cmd_type        ctl
);

   dtl_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dtl_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dtl_pkg::ST_IDLE: begin
            if (req_valid) state_in = dtl_pkg::ST_EXEC;
         end
         dtl_pkg::ST_EXEC: begin
            state_in = dtl_pkg::ST_DIV;
         end
         dtl_pkg::ST_DIV: begin
            if (status.div_done) state_in = dtl_pkg::ST_EMIT;
         end
         dtl_pkg::ST_EMIT: begin
            if (status.slot_free) state_in = dtl_pkg::ST_IDLE;
         end
         default: state_in = dtl_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready    = 1'b0;
      ctl          = '0;
      unique case (state_ff)
         dtl_pkg::ST_IDLE: begin
            req_ready   = 1'b1;
            ctl.capture = req_valid;
         end
         dtl_pkg::ST_EXEC: begin
            ctl.execute = 1'b1;
         end
         dtl_pkg::ST_DIV: begin
            ctl.div_step = !status.div_done;
         end
         dtl_pkg::ST_EMIT: begin
            ctl.emit = status.slot_free;
         end
         default: ;
      endcase
   end

endmodule

`default_nettype wire

@@ design/dtl_datapath.sv @@
`default_nettype none

module dtl_datapath #(
   parameter int MAX_SYMBOL = dtl_pkg::MAX_SYMBOL_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_wr_en,
   input  wire logic [6:0]           csr_wr_data,
   input  wire dtl_pkg::ctl_cmd_type ctl,
   output dtl_pkg::dp_status_type    status,
   input  wire logic [1:0]           req_command,
   input  wire logic [7:0]           req_character,
   input  wire logic [5:0]           req_read_index,
   input  wire logic                 rsp_ready,
   output logic                      rsp_valid,
   output logic                      rsp_complete,
   output logic [7:0]                rsp_last_char,
   output logic [6:0]                rsp_token_length,
   output logic [30:0]               rsp_magnitude,
   output logic                      rsp_is_negative,
   output logic [6:0]                rsp_scale,
   output logic signed [31:0]        rsp_int_value,
   output logic [7:0]                rsp_read_char
);

   localparam int AddrWidth = (MAX_SYMBOL > 1) ? $clog2(MAX_SYMBOL) : 1;
   localparam logic [8:0] SymCount = 9'(MAX_SYMBOL);

   logic [7:0] mem [MAX_SYMBOL];

   dtl_pkg::cmd_type cap_cmd_ff;
   logic [7:0]       cap_char_ff;
   logic [5:0]       cap_idx_ff;

   logic [6:0]  max_len_ff;
   logic [30:0] acc_ff, acc_in;
   logic        minus_ff, minus_in;
   logic        point_ff, point_in;
   logic [6:0]  scale_ff, scale_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        done_ff, done_in;
   logic [7:0]  recent_ff, recent_in;

   logic [30:0] quo_ff, quo_in;
   logic [3:0]  rem_ff, rem_in;
   logic [7:0]  rd_data_ff;
   logic        rd_hit_ff;

   logic        rsp_valid_ff, rsp_valid_in;

   logic                 mem_we;
   logic [AddrWidth-1:0] wr_addr;
   logic [AddrWidth-1:0] rd_addr;
   logic [8:0]           limit;
   logic                 full;
   logic [34:0]          acc_x10;
   logic [63:0]          div_prod;
   logic [31:0]          quo_signed;

   assign wr_addr  = AddrWidth'(cnt_ff);
   assign rd_addr  = AddrWidth'(cap_idx_ff);
   assign limit    = ({2'b00, max_len_ff} < SymCount) ? {2'b00, max_len_ff} : SymCount;
   assign full     = {2'b00, cnt_ff} >= limit;
   assign acc_x10  = ({4'b0000, acc_ff} << 3) + ({4'b0000, acc_ff} << 1)
                     + 35'(cap_char_ff - dtl_pkg::CHAR_DIGIT_LO);
   assign div_prod = {1'b0, quo_ff} * dtl_pkg::DIV10_RECIP;
   assign quo_signed = minus_ff ? (32'd0 - {1'b0, quo_ff}) : {1'b0, quo_ff};

   assign status    = '{div_done: (rem_ff == 4'd0), slot_free: (!rsp_valid_ff || rsp_ready)};
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         cap_cmd_ff  <= dtl_pkg::cmd_type'(req_command);
         cap_char_ff <= req_character;
         cap_idx_ff  <= req_read_index;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= dtl_pkg::MAX_LENGTH_RESET;
      end else if (csr_wr_en) begin
         max_len_ff <= csr_wr_data;
      end
   end

   always_comb begin
      acc_in    = acc_ff;
      minus_in  = minus_ff;
      point_in  = point_ff;
      scale_in  = scale_ff;
      cnt_in    = cnt_ff;
      done_in   = done_ff;
      recent_in = recent_ff;
      mem_we    = 1'b0;
      if (ctl.execute) begin
         unique case (cap_cmd_ff)
            dtl_pkg::CMD_BEGIN: begin
               acc_in    = '0;
               minus_in  = 1'b0;
               point_in  = 1'b0;
               scale_in  = '0;
               cnt_in    = '0;
               done_in   = 1'b0;
               recent_in = '0;
            end
            dtl_pkg::CMD_PRESENT: begin
               if (!done_ff) begin
                  recent_in = cap_char_ff;
                  if (cap_char_ff != dtl_pkg::CHAR_SPACE) begin
                     if (!dtl_pkg::is_accepted(cap_char_ff) || full) begin
                        done_in = 1'b1;
                     end else begin
                        mem_we = 1'b1;
                        cnt_in = cnt_ff + 7'd1;
                        if (point_ff && (scale_ff != dtl_pkg::SCALE_MAX)) begin
                           scale_in = scale_ff + 7'd1;
                        end
                        if (cap_char_ff == dtl_pkg::CHAR_MINUS) begin
                           minus_in = 1'b1;
                        end else if (dtl_pkg::is_digit(cap_char_ff)) begin
                           acc_in = (acc_x10 > {4'b0000, dtl_pkg::MAG_MAX}) ?
                                    dtl_pkg::MAG_MAX : acc_x10[30:0];
                        end else if ((cap_char_ff == dtl_pkg::CHAR_POINT)
                                     || (cap_char_ff == dtl_pkg::CHAR_COMMA)) begin
                           point_in = 1'b1;
                        end
                     end
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      if (ctl.execute) begin
         if (scale_in < dtl_pkg::SCALE_DIV_LIMIT) begin
            quo_in = acc_in;
            rem_in = scale_in[3:0];
         end else begin
            quo_in = '0;
            rem_in = '0;
         end
      end else if (ctl.div_step) begin
         quo_in = {2'b00, div_prod[63:dtl_pkg::DIV10_SHIFT]};
         rem_in = rem_ff - 4'd1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctl.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         minus_ff     <= 1'b0;
         point_ff     <= 1'b0;
         scale_ff     <= '0;
         cnt_ff       <= '0;
         done_ff      <= 1'b0;
         recent_ff    <= '0;
         rem_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         minus_ff     <= minus_in;
         point_ff     <= point_in;
         scale_ff     <= scale_in;
         cnt_ff       <= cnt_in;
         done_ff      <= done_in;
         recent_ff    <= recent_in;
         rem_ff       <= rem_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= cap_char_ff;
      end
      if (ctl.execute) begin
         rd_data_ff <= mem[rd_addr];
         rd_hit_ff  <= (cap_cmd_ff == dtl_pkg::CMD_READ) && ({1'b0, cap_idx_ff} < cnt_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.emit) begin
         rsp_complete     <= done_ff;
         rsp_last_char    <= recent_ff;
         rsp_token_length <= cnt_ff;
         rsp_magnitude    <= acc_ff;
         rsp_is_negative  <= minus_ff;
         rsp_scale        <= scale_ff;
         rsp_int_value    <= quo_signed;
         rsp_read_char    <= rd_hit_ff ? rd_data_ff : 8'd0;
      end
   end

   assert property (@(posedge clock) disable iff (reset) {2'b00, cnt_ff} <= SymCount)
      else $error("stored count beyond store depth");

   assert property (@(posedge clock) disable iff (reset) scale_ff <= cnt_ff)
      else $error("scale exceeds stored count");

   assert property (@(posedge clock) disable iff (reset)
      done_ff && !(ctl.execute && (cap_cmd_ff == dtl_pkg::CMD_BEGIN)) |=> $stable(cnt_ff))
      else $error("count moved after token completed");

   assert property (@(posedge clock) disable iff (reset) ctl.emit |=> rsp_valid_ff)
      else $error("emitted transaction not presented");

endmodule

`default_nettype wire

@@ design/decimal_token_lexer_core.sv @@
// Decimal token lexer: each request transaction carries a command (begin, present byte, read
// stored byte) and returns exactly one response transaction with the token status: complete
// flag, last byte, length, saturating magnitude, sign, scale, the integer value truncated
// toward zero and, for a read, the stored byte. The csr port sets the maximum token length
// (reset 64). One request is processed at a time: after acceptance it is executed, then the
// divide-by-ten unit removes one decimal place per cycle until the scale is used up (no step
// when scale is 10 or more, where the integer value is zero), then the response is emitted
// once the output register is free; the response sits in that register so the next request
// is accepted while it waits to be taken.
`default_nettype none

module decimal_token_lexer_core #(
   parameter int MAX_SYMBOL = dtl_pkg::MAX_SYMBOL_DEFAULT
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_wr_en,
   input  wire logic [6:0] csr_wr_data,
   dtl_req_if.sink         req_if,
   dtl_rsp_if.source       rsp_if
);

   dtl_pkg::ctl_cmd_type   ctl;
   dtl_pkg::dp_status_type status;
   logic                   req_ready;

   assign req_if.ready = req_ready;

   dtl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .status    (status),
      .req_ready (req_ready),
      .ctl       (ctl)
   );

   dtl_datapath #(
      .MAX_SYMBOL (MAX_SYMBOL)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .ctl              (ctl),
      .status           (status),
      .req_command      (req_if.command),
      .req_character    (req_if.character),
      .req_read_index   (req_if.read_index),
      .rsp_ready        (rsp_if.ready),
      .rsp_valid        (rsp_if.valid),
      .rsp_complete     (rsp_if.complete),
      .rsp_last_char    (rsp_if.last_char),
      .rsp_token_length (rsp_if.token_length),
      .rsp_magnitude    (rsp_if.magnitude),
      .rsp_is_negative  (rsp_if.is_negative),
      .rsp_scale        (rsp_if.scale),
      .rsp_int_value    (rsp_if.int_value),
      .rsp_read_char    (rsp_if.read_char)
   );

endmodule

`default_nettype wire
